FILE: rtl/core/game_port_axis_timers_core_defines.svh
// ----------------------------------------------------------------------------
// Game port core assertion macros
// Shared concurrent assertion forms for the game port checker.
// ----------------------------------------------------------------------------
`ifndef GAME_PORT_AXIS_TIMERS_CORE_DEFINES_SVH
`define GAME_PORT_AXIS_TIMERS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GPT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gpt_pkg.sv
// ----------------------------------------------------------------------------
// Game port package
// Types, codes and arithmetic constants shared by the game port modules.
// ----------------------------------------------------------------------------
package gpt_pkg;

  // Axis slots and the subset that actually has a timer.
  localparam int unsigned AXIS_SLOTS = 4;
  localparam int unsigned NUM_AXES   = 4;
  localparam logic [AXIS_SLOTS-1:0] ALL_AXES   = 4'hf;
  localparam logic [AXIS_SLOTS-1:0] TIMED_AXES = AXIS_SLOTS'((1 << NUM_AXES) - 1);
  localparam int unsigned IDX_W = 2;

  // Field widths.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned BTN_W    = 8;
  localparam int unsigned TPU_W    = 8;
  localparam int unsigned COUNT_W  = 19;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Request codes carried in tuser.
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  // Register indexes (taken from paddr[2]).
  localparam logic REG_TPU = 1'b0;
  localparam logic [TPU_W-1:0] TPU_RESET = 8'd10;

  // Delay arithmetic: usec = ((pos + 32768) * 100 / 65) * 11 / 1000 + 24.
  localparam logic [POS_W-1:0] POS_BIAS = 16'h8000;
  localparam int unsigned X_W    = 23;   // biased * 100
  localparam int unsigned OHM_W  = 17;   // x / 65
  localparam int unsigned Y_W    = 21;   // ohms * 11
  localparam int unsigned Q2_W   = 12;   // y / 1000
  localparam int unsigned USEC_W = 11;   // q2 + 24
  localparam int unsigned OHM_SCALE  = 100;
  localparam int unsigned OHM_DIV    = 65;
  localparam int unsigned USEC_SCALE = 11;
  localparam int unsigned USEC_DIV   = 1000;
  localparam int unsigned USEC_BASE  = 24;
  localparam int unsigned DIV65_SHIFT   = 23;
  localparam int unsigned DIV65_MUL     = (1 << DIV65_SHIFT) / OHM_DIV;
  localparam int unsigned DIV1000_SHIFT = 21;
  localparam int unsigned DIV1000_MUL   = (1 << DIV1000_SHIFT) / USEC_DIV;

  // Reciprocal products and correction remainders inside the delay pipeline.
  localparam int unsigned P1_W = X_W + OHM_W;
  localparam int unsigned P2_W = Y_W + Q2_W;
  localparam int unsigned R1_W = X_W + 1;
  localparam int unsigned R2_W = Y_W + 1;

  // Command queue.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_TICK
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                          kind;
    logic [AXIS_SLOTS-1:0][POS_W-1:0]   pos;
    logic [AXIS_SLOTS-1:0]              present;
    logic [BTN_W-1:0]                   buttons;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             present;
    logic [POS_W-1:0] pos;
  } delay_req_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] count;
  } delay_res_t;

endpackage

FILE: rtl/core/game_port_axis_timers_core.sv
// ----------------------------------------------------------------------------
// Game port axis timers core
// PC game port with four one-shot axis timers, a tick input and read port.
// ----------------------------------------------------------------------------
// Each request on the input stream is a bus read, a bus write or a timer tick,
// selected by in_tuser. A write sets all four axis-running bits and reloads
// each axis countdown with ticks_per_usec * (((pos + 32768) * 100 / 65) * 11
// / 1000 + 24); an absent axis gets zero and its bit stays set. A tick
// decrements every nonzero countdown and clears the axis bit when it reaches
// zero. A read returns one byte, the running bits ORed with the button byte;
// writes and ticks return nothing. Reads and ticks are executed straight from
// the idle state, so a stream of them runs at one request per clock once
// queued, unless a read result is stalled. A write holds the back end:
// four axis loads are issued one per cycle into a shared seven-stage delay
// pipeline (two multiply-by-reciprocal divisions and the final scale), and
// the back end waits for it to drain. The two-entry command queue keeps
// accepting requests meanwhile until it fills. A pending read result waits in
// the output register without stopping ticks and writes queued behind it only
// when the next read arrives. ticks_per_usec lives at byte address 0 of the
// configuration port and resets to 10; it may be written only while idle.
// ----------------------------------------------------------------------------
module game_port_axis_timers_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] axis_pos_0, [31:16] axis_pos_1, [47:32] axis_pos_2,
  // [63:48] axis_pos_3, [67:64] axis_present, [75:68] button_bits, [79:76] 0
  input  logic [gpt_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] mode
  input  logic [gpt_pkg::MODE_W-1:0]        in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] read_data
  output logic [gpt_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gpt_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gpt_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gpt_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [gpt_pkg::TPU_W-1:0] tpu_r, tpu_nxt;
  logic                      cfg_wr;
  logic                      reg_idx;

  logic                q_valid;
  gpt_pkg::cmd_t       q_cmd;
  logic                q_pop;
  gpt_pkg::delay_req_t req;
  gpt_pkg::delay_res_t res;
  logic                pipe_busy;

  // Registers are word aligned, so bit 2 of the address picks the register.
  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    tpu_nxt = tpu_r;
    if (cfg_wr && reg_idx == gpt_pkg::REG_TPU) begin
      tpu_nxt = cfg_pwdata[gpt_pkg::TPU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= gpt_pkg::TPU_RESET;
    end else begin
      tpu_r <= tpu_nxt;
    end
  end

  // Reads of unmapped addresses return zero.
  assign cfg_prdata = (reg_idx == gpt_pkg::REG_TPU) ? gpt_pkg::CFG_DATA_W'(tpu_r) : '0;

  // Front end: decode and queue requests.
  gpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // Back end: timers, ticks and the read result register.
  gpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .req        (req),
    .res        (res),
    .pipe_busy  (pipe_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shared delay pipeline for the axis loads of a write.
  gpt_delay u_delay (
    .clk   (clk),
    .rst_n (rst_n),
    .tpu   (tpu_r),
    .req   (req),
    .res   (res),
    .busy  (pipe_busy)
  );

endmodule

FILE: rtl/core/gpt_front.sv
// ----------------------------------------------------------------------------
// Game port front end
// Accepts requests, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module gpt_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gpt_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [gpt_pkg::MODE_W-1:0]      in_tuser,
  output logic                            q_valid,
  output gpt_pkg::cmd_t                   q_cmd,
  input  logic                            q_pop
);

  gpt_pkg::cmd_t              mem_r [gpt_pkg::QDEPTH];
  logic [gpt_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gpt_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gpt_pkg::QCNT_W-1:0] count_r, count_nxt;
  gpt_pkg::cmd_t              cmd;
  logic                       keep;
  logic                       push;

  // Decode the request. Mode 3 is accepted and dropped.
  always_comb begin
    cmd.pos[0]  = in_tdata[15:0];
    cmd.pos[1]  = in_tdata[31:16];
    cmd.pos[2]  = in_tdata[47:32];
    cmd.pos[3]  = in_tdata[63:48];
    cmd.present = in_tdata[67:64] & gpt_pkg::TIMED_AXES;
    cmd.buttons = in_tdata[75:68];
    keep        = 1'b1;
    unique case (in_tuser)
      gpt_pkg::MODE_READ:  cmd.kind = gpt_pkg::CMD_READ;
      gpt_pkg::MODE_WRITE: cmd.kind = gpt_pkg::CMD_WRITE;
      gpt_pkg::MODE_TICK:  cmd.kind = gpt_pkg::CMD_TICK;
      default: begin
        cmd.kind = gpt_pkg::CMD_READ;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_tready = (count_r != gpt_pkg::QCNT_W'(gpt_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (count_r != '0);
  assign q_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + gpt_pkg::QCNT_W'(push) - gpt_pkg::QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: rtl/core/gpt_delay.sv
// ----------------------------------------------------------------------------
// Game port delay pipeline
// Seven-stage pipeline that turns an axis position into a countdown load.
// ----------------------------------------------------------------------------
module gpt_delay (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [gpt_pkg::TPU_W-1:0]    tpu,
  input  gpt_pkg::delay_req_t          req,
  output gpt_pkg::delay_res_t          res,
  output logic                         busy
);

  // Stage valid bits and tags.
  logic [6:0]                 v_r;
  logic [6:0][gpt_pkg::IDX_W-1:0] idx_r;
  logic [6:0]                 pres_r;

  logic [gpt_pkg::X_W-1:0]     s1_x_r, s2_x_r;
  logic [gpt_pkg::OHM_W-1:0]   s2_q_r, s3_ohm_r;
  logic [gpt_pkg::Y_W-1:0]     s4_y_r, s5_y_r;
  logic [gpt_pkg::Q2_W-1:0]    s5_q_r;
  logic [gpt_pkg::USEC_W-1:0]  s6_usec_r;
  logic [gpt_pkg::COUNT_W-1:0] cnt_r;

  logic [gpt_pkg::POS_W-1:0]   biased;
  logic [gpt_pkg::X_W-1:0]     s1_x_nxt;
  logic [gpt_pkg::P1_W-1:0]    p1;
  logic [gpt_pkg::OHM_W-1:0]   s2_q_nxt;
  logic [gpt_pkg::R1_W-1:0]    r1;
  logic [gpt_pkg::OHM_W-1:0]   s3_ohm_nxt;
  logic [gpt_pkg::Y_W-1:0]     s4_y_nxt;
  logic [gpt_pkg::P2_W-1:0]    p2;
  logic [gpt_pkg::Q2_W-1:0]    s5_q_nxt;
  logic [gpt_pkg::R2_W-1:0]    r2;
  logic [gpt_pkg::USEC_W-1:0]  s6_usec_nxt;
  logic [gpt_pkg::COUNT_W-1:0] cnt_nxt;

  always_comb begin
    // Flipping the sign bit adds the 32768 bias.
    biased   = req.pos ^ gpt_pkg::POS_BIAS;
    s1_x_nxt = gpt_pkg::X_W'(biased) * gpt_pkg::X_W'(gpt_pkg::OHM_SCALE);
    // Divide by 65: reciprocal estimate, then one correction step.
    p1       = gpt_pkg::P1_W'(s1_x_r) * gpt_pkg::P1_W'(gpt_pkg::DIV65_MUL);
    s2_q_nxt = p1[gpt_pkg::DIV65_SHIFT +: gpt_pkg::OHM_W];
    r1       = gpt_pkg::R1_W'(s2_x_r)
             - gpt_pkg::R1_W'(s2_q_r) * gpt_pkg::R1_W'(gpt_pkg::OHM_DIV);
    s3_ohm_nxt = s2_q_r + gpt_pkg::OHM_W'(r1 >= gpt_pkg::R1_W'(gpt_pkg::OHM_DIV));
    s4_y_nxt = gpt_pkg::Y_W'(s3_ohm_r) * gpt_pkg::Y_W'(gpt_pkg::USEC_SCALE);
    // Divide by 1000 the same way.
    p2       = gpt_pkg::P2_W'(s4_y_r) * gpt_pkg::P2_W'(gpt_pkg::DIV1000_MUL);
    s5_q_nxt = p2[gpt_pkg::DIV1000_SHIFT +: gpt_pkg::Q2_W];
    r2       = gpt_pkg::R2_W'(s5_y_r)
             - gpt_pkg::R2_W'(s5_q_r) * gpt_pkg::R2_W'(gpt_pkg::USEC_DIV);
    s6_usec_nxt = gpt_pkg::USEC_W'(s5_q_r)
                + gpt_pkg::USEC_W'(r2 >= gpt_pkg::R2_W'(gpt_pkg::USEC_DIV))
                + gpt_pkg::USEC_W'(gpt_pkg::USEC_BASE);
    // An absent axis loads zero so its running bit stays set.
    cnt_nxt  = pres_r[5] ? gpt_pkg::COUNT_W'(tpu) * gpt_pkg::COUNT_W'(s6_usec_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= {idx_r[5:0], req.idx};
    pres_r    <= {pres_r[5:0], req.present};
    s1_x_r    <= s1_x_nxt;
    s2_x_r    <= s1_x_r;
    s2_q_r    <= s2_q_nxt;
    s3_ohm_r  <= s3_ohm_nxt;
    s4_y_r    <= s4_y_nxt;
    s5_y_r    <= s4_y_r;
    s5_q_r    <= s5_q_nxt;
    s6_usec_r <= s6_usec_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign res.valid = v_r[6];
  assign res.idx   = idx_r[6];
  assign res.count = cnt_r;
  assign busy      = |v_r;

endmodule

FILE: rtl/core/gpt_back.sv
// ----------------------------------------------------------------------------
// Game port back end
// Executes queued commands: axis timers, tick countdown and read results.
// ----------------------------------------------------------------------------
module gpt_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  gpt_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  output gpt_pkg::delay_req_t              req,
  input  gpt_pkg::delay_res_t              res,
  input  logic                             pipe_busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gpt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  gpt_pkg::back_state_t state_r, state_nxt;

  logic [gpt_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [gpt_pkg::POS_W-1:0]      pos_r [gpt_pkg::AXIS_SLOTS];
  logic [gpt_pkg::AXIS_SLOTS-1:0] pres_r;
  logic [gpt_pkg::AXIS_SLOTS-1:0] run_r, run_nxt;
  logic [gpt_pkg::COUNT_W-1:0]    cnt_r [gpt_pkg::AXIS_SLOTS];
  logic [gpt_pkg::COUNT_W-1:0]    cnt_nxt [gpt_pkg::AXIS_SLOTS];
  logic                           ovld_r, ovld_nxt;
  logic [gpt_pkg::OUT_DATA_W-1:0] odata_r, odata_nxt;

  logic out_free;
  logic load_wr;
  logic do_tick;
  logic do_read;

  assign out_free = !ovld_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpt_pkg::BK_IDLE: begin
        if (q_valid && q_cmd.kind == gpt_pkg::CMD_WRITE) begin
          state_nxt = gpt_pkg::BK_ISSUE;
        end
      end
      gpt_pkg::BK_ISSUE: begin
        if (idx_r == gpt_pkg::IDX_W'(gpt_pkg::AXIS_SLOTS - 1)) begin
          state_nxt = gpt_pkg::BK_DRAIN;
        end
      end
      gpt_pkg::BK_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = gpt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = gpt_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load_wr     = 1'b0;
    do_tick     = 1'b0;
    do_read     = 1'b0;
    req.valid   = 1'b0;
    req.idx     = idx_r;
    req.present = pres_r[idx_r];
    req.pos     = pos_r[idx_r];
    unique case (state_r)
      gpt_pkg::BK_IDLE: begin
        if (q_valid) begin
          load_wr = (q_cmd.kind == gpt_pkg::CMD_WRITE);
          do_tick = (q_cmd.kind == gpt_pkg::CMD_TICK);
          do_read = (q_cmd.kind == gpt_pkg::CMD_READ) && out_free;
        end
      end
      gpt_pkg::BK_ISSUE: req.valid = 1'b1;
      gpt_pkg::BK_DRAIN: req.valid = 1'b0;
      default:           req.valid = 1'b0;
    endcase
  end

  assign q_pop = load_wr || do_tick || do_read;

  // Datapath updates.
  always_comb begin
    idx_nxt   = (state_r == gpt_pkg::BK_ISSUE) ? idx_r + 1'b1 : '0;
    run_nxt   = run_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    for (int i = 0; i < gpt_pkg::AXIS_SLOTS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (load_wr) begin
      run_nxt = run_r | gpt_pkg::ALL_AXES;
    end
    if (do_tick) begin
      for (int i = 0; i < gpt_pkg::AXIS_SLOTS; i++) begin
        if (cnt_r[i] != '0) begin
          cnt_nxt[i] = cnt_r[i] - 1'b1;
          if (cnt_r[i] == gpt_pkg::COUNT_W'(1)) begin
            run_nxt[i] = 1'b0;
          end
        end
      end
    end
    if (res.valid) begin
      cnt_nxt[res.idx] = res.count;
    end
    if (do_read) begin
      ovld_nxt  = 1'b1;
      odata_nxt = gpt_pkg::OUT_DATA_W'(run_r) | q_cmd.buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpt_pkg::BK_IDLE;
      idx_r   <= '0;
      run_r   <= '0;
      ovld_r  <= 1'b0;
      for (int i = 0; i < gpt_pkg::AXIS_SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      run_r   <= run_nxt;
      ovld_r  <= ovld_nxt;
      for (int i = 0; i < gpt_pkg::AXIS_SLOTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    if (load_wr) begin
      pres_r <= q_cmd.present;
      for (int i = 0; i < gpt_pkg::AXIS_SLOTS; i++) begin
        pos_r[i] <= q_cmd.pos[i];
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

endmodule

FILE: rtl/core/gpt_checker.sv
// ----------------------------------------------------------------------------
// Game port checker
// Port-level assertions for the game port core, bound to the top level.
// ----------------------------------------------------------------------------
`include "game_port_axis_timers_core_defines.svh"

module gpt_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [gpt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gpt_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gpt_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  input  logic [gpt_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  input  logic                              cfg_pready
);

  // A stalled read result holds its value.
  `GPT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "read result changed while stalled")

  // The port never stalls and only the low byte of the register exists.
  `GPT_ASSERT_IMPLY(a_cfg_shape, 1'b1, cfg_pready && cfg_prdata[31:8] == 24'd0, "config port shape violated")

  // A written ticks_per_usec value reads back on the next cycle.
  `GPT_ASSERT_NEXT(a_cfg_readback, cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == gpt_pkg::REG_TPU, cfg_paddr[2] != gpt_pkg::REG_TPU || cfg_prdata[7:0] == $past(cfg_pwdata[7:0]), "ticks_per_usec readback mismatch")

  // Right after reset the queue is empty and no result is pending.
  `GPT_ASSERT_IMPLY(a_post_reset, $past(!rst_n), in_tready && !out_tvalid, "block not empty after reset")

endmodule

bind game_port_axis_timers_core gpt_checker u_gpt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Game port axis timers testbench
// Streams bus reads, bus writes and timer ticks into the game port core,
// predicts every read byte from its own model of the axis timers and checks
// each returned byte in order, across several ticks_per_usec settings.
// ----------------------------------------------------------------------------
module tb;

  // Run length and pacing.
  localparam int unsigned CLOCK_LIMIT     = 600000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned PHASE_QUOTA     = 225;
  localparam int unsigned IDLE_PERCENT    = 36;
  localparam int unsigned RESET_CYCLES    = 11;

  // Delay arithmetic, written out independently of the design.
  localparam int unsigned BIAS_FLIP   = 32'h8000;
  localparam int unsigned OHMS_MUL    = 100;
  localparam int unsigned OHMS_DIV    = 65;
  localparam int unsigned USEC_MUL    = 11;
  localparam int unsigned USEC_DIV    = 1000;
  localparam int unsigned USEC_OFFSET = 24;
  localparam logic [gpt_pkg::TPU_W-1:0] RATE_AT_RESET = 8'd10;

  // The fourth request code is not decoded; the core must drop it silently.
  localparam logic [gpt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [gpt_pkg::CFG_ADDR_W-1:0] TPU_ADDR =
    gpt_pkg::CFG_ADDR_W'(4 * gpt_pkg::REG_TPU);

  // One request as it travels on the input stream.
  typedef struct packed {
    logic [gpt_pkg::MODE_W-1:0]           mode;
    logic [3:0][gpt_pkg::POS_W-1:0]       pos;
    logic [3:0]                           present;
    logic [gpt_pkg::BTN_W-1:0]            buttons;
  } port_request_t;

  // Tracks the running bits and the four countdowns, and holds the read
  // bytes that the core still owes us, oldest first.
  class port_byte_predictor;
    logic [gpt_pkg::TPU_W-1:0]   rate;
    logic [3:0]                  running;
    logic [gpt_pkg::COUNT_W-1:0] countdown [4];
    logic [7:0]                  bytes_due [$];
    int unsigned                 errors;

    function new();
      rate    = RATE_AT_RESET;
      running = '0;
      foreach (countdown[i]) countdown[i] = '0;
      errors  = 0;
    endfunction

    function logic [gpt_pkg::COUNT_W-1:0] axis_load(logic [gpt_pkg::POS_W-1:0] pos);
      int unsigned biased, ohms, usec;
      biased = 32'(pos) ^ BIAS_FLIP;
      ohms   = biased * OHMS_MUL / OHMS_DIV;
      usec   = ohms * USEC_MUL / USEC_DIV + USEC_OFFSET;
      return gpt_pkg::COUNT_W'(32'(rate) * usec);
    endfunction

    function void note_request(port_request_t r);
      case (r.mode)
        gpt_pkg::MODE_READ: begin
          bytes_due.push_back({4'd0, running} | r.buttons);
        end
        gpt_pkg::MODE_WRITE: begin
          running = 4'hf;
          for (int i = 0; i < 4; i++) begin
            if (i < gpt_pkg::NUM_AXES && r.present[i])
              countdown[i] = axis_load(r.pos[i]);
            else
              countdown[i] = '0;
          end
        end
        gpt_pkg::MODE_TICK: begin
          for (int i = 0; i < 4; i++) begin
            if (countdown[i] != 0) begin
              countdown[i] = countdown[i] - 1'b1;
              if (countdown[i] == 0) running[i] = 1'b0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_read_data(logic [7:0] got);
      logic [7:0] want;
      if (bytes_due.size() == 0) begin
        $error("read_data: no read pending, got %02h", got);
        errors++;
      end else begin
        want = bytes_due.pop_front();
        if (got !== want) begin
          $error("read_data: expected %02h, got %02h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input starts at a known value before the first edge.
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [gpt_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [gpt_pkg::MODE_W-1:0]     in_tuser = gpt_pkg::MODE_READ;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [gpt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [gpt_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [gpt_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [gpt_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // When set, neither side inserts idle cycles.
  logic steady = 1'b0;
  int unsigned cycle_count = 0;

  port_byte_predictor book = new();

  always #6 clk = ~clk;

  game_port_axis_timers_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Result side: a byte is taken at an edge where valid and ready are both
  // high, then ready is redrawn for the next cycle. Sampling happens before
  // the edge's updates land, so the handshake seen here is the one that
  // actually completed.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_read_data(out_tdata);
    out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog for a core that hangs or swallows a read.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CLOCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Positions lean toward the low end of travel so that, at small rates, the
  // countdowns actually run out within a sequence of ticks.
  function automatic logic [gpt_pkg::POS_W-1:0] pick_pos();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return gpt_pkg::POS_W'($urandom);
      default: return gpt_pkg::POS_W'(16'h8000 + $urandom_range(1500));
    endcase
  endfunction

  function automatic port_request_t make_request(logic [gpt_pkg::MODE_W-1:0] mode);
    port_request_t r;
    r.mode    = mode;
    for (int i = 0; i < 4; i++) r.pos[i] = pick_pos();
    r.present = 4'($urandom_range(15));
    r.buttons = gpt_pkg::BTN_W'($urandom_range(255));
    return r;
  endfunction

  function automatic port_request_t fixed_request(logic [gpt_pkg::MODE_W-1:0] mode,
                                                 logic [3:0][gpt_pkg::POS_W-1:0] pos,
                                                 logic [3:0] present,
                                                 logic [gpt_pkg::BTN_W-1:0] buttons);
    port_request_t r;
    r.mode    = mode;
    r.pos     = pos;
    r.present = present;
    r.buttons = buttons;
    return r;
  endfunction

  // Offers one request, with random idle cycles ahead of it, and returns at
  // the edge where the core takes it. Valid is left high so that back-to-back
  // requests need no extra assignment in the acceptance step.
  task automatic send_request(input port_request_t r);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {4'd0, r.buttons, r.present, r.pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_request(r);
  endtask

  // Waits out every owed read byte, then gives a queued write time to finish
  // its delay pipeline, since writes and ticks produce nothing to wait for.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (book.bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer on the rate register: setup, then access, then a return
  // to idle so that back-to-back transfers never overlap on the bus.
  task automatic cfg_access(input logic write, input logic [gpt_pkg::TPU_W-1:0] value);
    logic [gpt_pkg::CFG_DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= TPU_ADDR;
    cfg_pwdata  <= gpt_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (write) begin
      book.rate = value;
    end else if (got !== gpt_pkg::CFG_DATA_W'(book.rate)) begin
      $error("ticks_per_usec: expected %0d, got %0d", book.rate, got);
      book.errors++;
    end
    @(posedge clk);
  endtask

  // Mostly well-formed sequences: a write that fires the timers, a run of
  // ticks that at small rates is long enough to let some axes expire, reads
  // scattered through the run, and a read at the end. The rest is random noise,
  // including the unused request code, which does not count toward the quota.
  task automatic run_random(input int unsigned quota);
    int unsigned done, span, run_len, n;
    port_request_t r;
    done = 0;
    while (done < quota) begin
      if ($urandom_range(9) < 7) begin
        send_request(make_request(gpt_pkg::MODE_WRITE));
        done++;
        if (book.rate == 0)
          span = 30;
        else if (book.rate > 3)
          span = 120;
        else
          span = 40 * book.rate + 20;
        run_len = $urandom_range(span, 1);
        repeat (run_len) begin
          if ($urandom_range(3) == 0) begin
            send_request(make_request(gpt_pkg::MODE_READ));
            done++;
          end
          send_request(make_request(gpt_pkg::MODE_TICK));
          done++;
        end
        send_request(make_request(gpt_pkg::MODE_READ));
        done++;
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          r = make_request(gpt_pkg::MODE_W'($urandom_range(3)));
          send_request(r);
          if (r.mode != MODE_UNUSED) done++;
        end
      end
    end
  endtask

  initial begin
    // Rate settings per phase: both range ends, zero (every loaded count is
    // zero so nothing ever expires), and small values; axes time out up to 3.
    int unsigned phase_rates [7];
    phase_rates = '{1, 255, 0, 2, 3, 1, 7};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset rate. Reads right after reset see no
    // running bits, and the unused code must leave state alone.
    cfg_access(1'b0, '0);
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'hff));
    send_request(fixed_request(gpt_pkg::MODE_TICK, '0, 4'h0, 8'h00));
    send_request(fixed_request(MODE_UNUSED, '1, 4'hf, 8'hff));
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'h00));
    // A write with no axis present loads zero counts, so every bit stays set
    // through ticks.
    send_request(fixed_request(gpt_pkg::MODE_WRITE,
                               {16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
                               4'h0, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_TICK, '0, 4'h0, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'h00));
    // All axes present at the position extremes and around zero.
    send_request(fixed_request(gpt_pkg::MODE_WRITE,
                               {16'hffff, 16'h0000, 16'h7fff, 16'h8000},
                               4'hf, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'ha5));
    send_request(fixed_request(gpt_pkg::MODE_TICK, '0, 4'h0, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_TICK, '0, 4'h0, 8'h00));
    // A second write while the countdowns are still running reloads them.
    send_request(fixed_request(gpt_pkg::MODE_WRITE,
                               {16'h1234, 16'hedcb, 16'h8000, 16'h8000},
                               4'b0101, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'h50));
    send_request(fixed_request(MODE_UNUSED, {16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
                               4'ha, 8'h5a));
    send_request(fixed_request(gpt_pkg::MODE_TICK, '0, 4'h0, 8'h00));
    send_request(fixed_request(gpt_pkg::MODE_READ, '0, 4'h0, 8'h0f));

    // Random phases, each at its own rate. One phase runs with no idling on
    // either side to keep the core busy back to back.
    foreach (phase_rates[p]) begin
      settle();
      cfg_access(1'b1, gpt_pkg::TPU_W'(phase_rates[p]));
      cfg_access(1'b0, '0);
      steady <= (p == 4);
      run_random(PHASE_QUOTA);
    end

    settle();
    if (book.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/gpt_pkg.sv
rtl/core/gpt_front.sv
rtl/core/gpt_delay.sv
rtl/core/gpt_back.sv
rtl/core/game_port_axis_timers_core.sv
rtl/core/gpt_checker.sv
tb/sv/tb.sv
